@@ hdl/buddy_tree_page_allocator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Buddy tree page allocator: assertion macros
// Shared property forms for the checker, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_TREE_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_TREE_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bta_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy tree page allocator package
// Field widths, request and status codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package bta_pkg;

    // field widths
    localparam int MARK_W   = 8;
    localparam int MODE_W   = 2;
    localparam int PAGE_W   = 16;
    localparam int ORDER_W  = 5;
    localparam int STATUS_W = 3;

    // request codes
    localparam logic [MODE_W-1:0] MODE_CLAIM_PAGE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE_PAGE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLAIM_BLOCK = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLAIMED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ORDER   = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DONE
    } t_state;

    // walk direction
    typedef enum logic {
        OP_SET,
        OP_CLR
    } t_op;

    // mark memory strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

@@ hdl/bta_if.sv @@
// ----------------------------------------------------------------------------
// Buddy tree page allocator channels
// Request and response channels, valid/ready, with source and sink modports.
// ----------------------------------------------------------------------------
interface bta_req_if;
    logic                        valid;
    logic                        ready;
    logic [bta_pkg::MODE_W-1:0]  mode;
    logic [bta_pkg::PAGE_W-1:0]  page_number;
    logic [bta_pkg::ORDER_W-1:0] block_order;

    modport source (output valid, output mode, output page_number, output block_order,
                    input ready);
    modport sink   (input valid, input mode, input page_number, input block_order,
                    output ready);
endinterface

interface bta_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bta_pkg::STATUS_W-1:0] status;
    logic [bta_pkg::PAGE_W-1:0]   block_page;

    modport source (output valid, output status, output block_page, input ready);
    modport sink   (input valid, input status, input block_page, output ready);
endinterface

@@ hdl/bta_mark_store.sv @@
// ----------------------------------------------------------------------------
// Buddy tree mark store
// Byte-wide mark memory, registered read, with a clearing pass
// over every byte after reset.
// ----------------------------------------------------------------------------
module bta_mark_store #(
    parameter int ADDR_W = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bta_pkg::t_mem_ctl          i_mem_ctl,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [bta_pkg::MARK_W-1:0] i_wr_data,
    output logic [bta_pkg::MARK_W-1:0] o_rd_data,
    output logic                       o_busy
);
    import bta_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [MARK_W-1:0] r_mem [0:DEPTH-1];
    logic [MARK_W-1:0] r_rd_data;
    logic              r_clearing;
    logic              n_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] n_clr_addr;

    // clearing pass sequencing
    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == {ADDR_W{1'b1}}) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    // write port: clearing pass wins, the sequencer is held off meanwhile
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_mem_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

endmodule

@@ hdl/bta_seq.sv @@
// ----------------------------------------------------------------------------
// Buddy tree sequencer
// Takes one request at a time, walks the tree by read-modify-write on the
// mark store, scans a row byte by byte for a block claim, holds the result.
// ----------------------------------------------------------------------------
module bta_seq #(
    parameter  int PAGE_INDEX_BITS = 16,
    localparam int ADDR_W = (PAGE_INDEX_BITS > 2) ? PAGE_INDEX_BITS - 2 : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bta_req_if.sink                      i_req,
    input  logic                         i_store_busy,
    input  logic [bta_pkg::MARK_W-1:0]   i_rd_data,
    output bta_pkg::t_mem_ctl            o_mem_ctl,
    output logic [ADDR_W-1:0]            o_rd_addr,
    output logic [ADDR_W-1:0]            o_wr_addr,
    output logic [bta_pkg::MARK_W-1:0]   o_wr_data,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [bta_pkg::STATUS_W-1:0] o_res_status,
    output logic [bta_pkg::PAGE_W-1:0]   o_res_block
);
    import bta_pkg::*;

    // node index wide enough for the tree and for {byte address, bit}
    localparam int NODE_W = (ADDR_W + 3 > PAGE_INDEX_BITS + 1) ? ADDR_W + 3
                                                               : PAGE_INDEX_BITS + 1;
    localparam logic [NODE_W-1:0]  LEAF_BASE     = NODE_W'(1) << PAGE_INDEX_BITS;
    localparam logic [NODE_W-1:0]  LEAF_OFS_MASK = LEAF_BASE - NODE_W'(1);
    localparam logic [ORDER_W-1:0] MAX_ORDER     = ORDER_W'(PAGE_INDEX_BITS);

    // lowest set bit of a byte
    function automatic logic [2:0] f_first_set(input logic [MARK_W-1:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = MARK_W - 1; i >= 0; i--) begin
            if (v[i]) idx = 3'(i);
        end
        return idx;
    endfunction

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic                r_first, n_first;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [PAGE_W-1:0]   r_block, n_block;
    logic [ORDER_W-1:0]  r_order, n_order;
    logic [ADDR_W-1:0]   r_scan_addr, n_scan_addr;
    logic [ADDR_W-1:0]   r_scan_end, n_scan_end;
    logic [MARK_W-1:0]   r_scan_mask, n_scan_mask;

    logic                accept;
    logic                too_large;
    logic [NODE_W-1:0]   req_leaf;
    logic [NODE_W-1:0]   req_root;
    logic [ADDR_W-1:0]   req_start;
    logic [ADDR_W-1:0]   req_end;
    logic [MARK_W-1:0]   req_mask;

    logic [2:0]          bit_k;
    logic [MARK_W-1:0]   bit_oh;
    logic [MARK_W-1:0]   buddy_oh;
    logic                cur_bit;
    logic                buddy_bit;
    logic                node_zero;
    logic                walk_halt;
    logic                walk_end;

    logic [MARK_W-1:0]   free_bits;
    logic                scan_hit;
    logic                scan_last;
    logic [NODE_W-1:0]   found_node;
    logic [NODE_W-1:0]   found_shift;

    // request decode
    always_comb begin
        accept    = i_req.valid && i_req.ready;
        too_large = i_req.block_order > MAX_ORDER;
        req_leaf  = LEAF_BASE | (NODE_W'(i_req.page_number) & LEAF_OFS_MASK);
        req_root  = NODE_W'(1) << (MAX_ORDER - i_req.block_order);
        req_start = req_root[NODE_W-1:3];
        req_end   = (req_start != '0) ? ADDR_W'((req_start << 1) - ADDR_W'(1)) : '0;
        if (req_start != '0) begin
            req_mask = '1;
        end else begin
            unique case (req_root[2:0])
                3'b001:  req_mask = 8'h02;
                3'b010:  req_mask = 8'h0C;
                3'b100:  req_mask = 8'hF0;
                default: req_mask = 8'h00;
            endcase
        end
    end

    // walk step evaluation on the byte just read
    always_comb begin
        bit_k     = r_node[2:0];
        bit_oh    = 8'h01 << bit_k;
        buddy_oh  = 8'h01 << (bit_k ^ 3'd1);
        cur_bit   = |(i_rd_data & bit_oh);
        buddy_bit = |(i_rd_data & buddy_oh);
        node_zero = r_node == '0;
        // halt before touching this node
        walk_halt = node_zero || ((r_op == OP_SET) ? cur_bit : !cur_bit);
        // stop after this step; a freed node with a live buddy ends the walk
        walk_end  = walk_halt || ((r_op == OP_CLR) && buddy_bit);
    end

    // row scan evaluation
    always_comb begin
        free_bits   = ~i_rd_data & r_scan_mask;
        scan_hit    = |free_bits;
        scan_last   = r_scan_addr == r_scan_end;
        found_node  = {r_scan_addr, f_first_set(free_bits)};
        found_shift = found_node << r_order;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.mode)
                        MODE_CLAIM_PAGE,
                        MODE_FREE_PAGE:   n_state = S_RD;
                        MODE_CLAIM_BLOCK: n_state = too_large ? S_DONE : S_SCAN_RD;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_RD:      n_state = S_EV;
            S_EV:      n_state = walk_end ? S_DONE : S_RD;
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                priority if (scan_hit) begin
                    n_state = S_RD;
                end else if (scan_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DONE:    n_state = i_res_ready ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // working registers
    always_comb begin
        n_op        = r_op;
        n_first     = r_first;
        n_node      = r_node;
        n_status    = r_status;
        n_block     = r_block;
        n_order     = r_order;
        n_scan_addr = r_scan_addr;
        n_scan_end  = r_scan_end;
        n_scan_mask = r_scan_mask;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_first     = 1'b1;
                    n_node      = req_leaf;
                    n_status    = ST_OK;
                    n_block     = '0;
                    n_order     = i_req.block_order;
                    n_scan_addr = req_start;
                    n_scan_end  = req_end;
                    n_scan_mask = req_mask;
                    n_op        = (i_req.mode == MODE_FREE_PAGE) ? OP_CLR : OP_SET;
                    if ((i_req.mode == MODE_CLAIM_BLOCK) && too_large) begin
                        n_status = ST_ORDER;
                    end
                end
            end
            S_EV: begin
                n_first = 1'b0;
                n_node  = r_node >> 1;
                if (r_first && walk_halt) begin
                    n_status = (r_op == OP_SET) ? ST_CLAIMED : ST_FREE;
                end
            end
            S_SCAN_EV: begin
                priority if (scan_hit) begin
                    n_op    = OP_SET;
                    n_first = 1'b0;
                    n_node  = found_node;
                    n_block = PAGE_W'(found_shift[PAGE_INDEX_BITS-1:0]);
                end else if (scan_last) begin
                    n_status = ST_NONE;
                    n_block  = '0;
                end else begin
                    n_scan_addr = r_scan_addr + ADDR_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_first     <= n_first;
        r_node      <= n_node;
        r_status    <= n_status;
        r_block     <= n_block;
        r_order     <= n_order;
        r_scan_addr <= n_scan_addr;
        r_scan_end  <= n_scan_end;
        r_scan_mask <= n_scan_mask;
    end

    // outputs
    always_comb begin
        i_req.ready     = (r_state == S_IDLE) && !i_store_busy;
        o_mem_ctl.rd_en = (r_state == S_RD) || (r_state == S_SCAN_RD);
        o_mem_ctl.wr_en = (r_state == S_EV) && !walk_halt;
        o_rd_addr       = (r_state == S_SCAN_RD) ? r_scan_addr : r_node[NODE_W-1:3];
        o_wr_addr       = r_node[NODE_W-1:3];
        o_wr_data       = (r_op == OP_SET) ? (i_rd_data | bit_oh) : (i_rd_data & ~bit_oh);
        o_res_valid     = r_state == S_DONE;
        o_res_status    = r_status;
        o_res_block     = r_block;
    end

endmodule

@@ hdl/buddy_tree_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Buddy tree page allocator unit
// Page and power-of-two block allocator over a bitmap tree of used marks.
// ----------------------------------------------------------------------------
// One request at a time, one response word per request. After reset the mark
// memory is cleared one byte a cycle over all 2^(PAGE_INDEX_BITS-2) bytes
// (16384 at the default), with the request channel held not ready. Every tree
// step is a read-modify-write through the mark memory, which has separate
// read and write ports: a read in S_RD, then evaluation and write in S_EV.
// A page claim or free visits at most PAGE_INDEX_BITS+1 levels, fewer when
// the walk stops early, then hands the word over. A block claim scans its
// row byte by byte, up to 2^(PAGE_INDEX_BITS-3) bytes for order 0, then
// climbs as a page claim. Order errors and the unused mode answer without a
// walk. The response sits in an output register, so the next request is
// taken while it waits.
// ----------------------------------------------------------------------------
module buddy_tree_page_allocator_unit #(
    parameter int PAGE_INDEX_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bta_req_if.sink   i_req,
    bta_rsp_if.source o_rsp
);
    import bta_pkg::*;

    localparam int ADDR_W = (PAGE_INDEX_BITS > 2) ? PAGE_INDEX_BITS - 2 : 1;

    t_mem_ctl            mem_ctl;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [MARK_W-1:0]   wr_data;
    logic [MARK_W-1:0]   rd_data;
    logic                store_busy;
    logic                res_valid;
    logic                res_ready;
    logic [STATUS_W-1:0] res_status;
    logic [PAGE_W-1:0]   res_block;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [PAGE_W-1:0]   r_out_block;
    logic                out_load;

    bta_mark_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mem_ctl (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data),
        .o_busy    (store_busy)
    );

    bta_seq #(
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_store_busy (store_busy),
        .i_rd_data    (rd_data),
        .o_mem_ctl    (mem_ctl),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res_status (res_status),
        .o_res_block  (res_block)
    );

    // output register: takes a word when empty or being drained
    always_comb begin
        res_ready   = !r_out_valid || o_rsp.ready;
        out_load    = res_valid && res_ready;
        n_out_valid = out_load || (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= res_status;
            r_out_block  <= res_block;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.block_page = r_out_block;

endmodule

@@ hdl/bta_checker.sv @@
// ----------------------------------------------------------------------------
// Buddy tree page allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "buddy_tree_page_allocator_unit_defines.svh"

module bta_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [bta_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [bta_pkg::PAGE_W-1:0]   i_rsp_block_page
);
    import bta_pkg::*;

    // a stalled response word holds
    `BTA_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_block_page), "response word changed while stalled")

    // one request at a time: ready drops once a word is taken
    `BTA_ASSERT_NEXT(a_one_at_a_time, i_req_valid && i_req_ready, !i_req_ready, "request taken while busy")

    // only a successful block claim carries a page address
    `BTA_ASSERT_NOW(a_block_only_ok, i_rsp_valid && (i_rsp_block_page != '0), i_rsp_status == ST_OK, "page address with error status")

    // status stays within the defined codes
    `BTA_ASSERT_NOW(a_status_range, i_rsp_valid, i_rsp_status <= ST_ORDER, "undefined status code")

endmodule

bind buddy_tree_page_allocator_unit bta_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_block_page (o_rsp.block_page)
);

@@ tb/bta_alloc_checker.sv @@
// ----------------------------------------------------------------------------
// Buddy tree page allocator: response checker
// Watches both channels. Every accepted request word is run through a local
// copy of the used-mark tree to predict its response word. Every accepted
// response word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module bta_alloc_checker #(
    parameter int PAGE_INDEX_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bta_req_if   i_req,
    bta_rsp_if   i_rsp,
    output int   o_errors,
    output int   o_pending
);
    import bta_pkg::*;

    localparam int unsigned NODE_COUNT = 1 << (PAGE_INDEX_BITS + 1);
    localparam int unsigned LEAF_BASE  = 1 << PAGE_INDEX_BITS;
    localparam int          REPORT_MAX = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   block_page;
    } t_rsp_word;

    // local copy of the tree, node 1 is the root
    bit        used_mark [NODE_COUNT];
    t_rsp_word expected_words [$];
    int        fault_count;

    assign o_errors = fault_count;

    // set marks from a node upward until an ancestor is already set
    function automatic void mark_claim_path(input int unsigned start);
        int unsigned node;
        node = start;
        while (node != 0 && !used_mark[node]) begin
            used_mark[node] = 1'b1;
            node = node >> 1;
        end
    endfunction

    // clear marks upward, stopping after a node whose buddy is still held
    function automatic void clear_free_path(input int unsigned start);
        int unsigned node;
        node = start;
        while (node != 0 && used_mark[node]) begin
            used_mark[node] = 1'b0;
            if (used_mark[node ^ 1]) return;
            node = node >> 1;
        end
    endfunction

    // apply one request to the tree and return the response it should give
    function automatic t_rsp_word alloc_outcome(
        input logic [MODE_W-1:0]  mode,
        input logic [PAGE_W-1:0]  page,
        input logic [ORDER_W-1:0] order
    );
        t_rsp_word   w;
        int unsigned leaf;
        int unsigned rank_base;
        int unsigned idx;
        w.status     = ST_OK;
        w.block_page = '0;
        leaf = LEAF_BASE + (int'(page) % LEAF_BASE);
        case (mode)
            MODE_CLAIM_PAGE: begin
                if (used_mark[leaf]) w.status = ST_CLAIMED;
                else mark_claim_path(leaf);
            end
            MODE_FREE_PAGE: begin
                if (!used_mark[leaf]) w.status = ST_FREE;
                else clear_free_path(leaf);
            end
            MODE_CLAIM_BLOCK: begin
                if (int'(order) > PAGE_INDEX_BITS) begin
                    w.status = ST_ORDER;
                end else begin
                    // lowest clear node of the row wins; descendants stay unmarked
                    rank_base = 1 << (PAGE_INDEX_BITS - int'(order));
                    w.status = ST_NONE;
                    for (idx = rank_base; idx < (rank_base << 1); idx++) begin
                        if (!used_mark[idx]) begin
                            mark_claim_path(idx);
                            w.status     = ST_OK;
                            w.block_page = PAGE_W'((idx - rank_base) << order);
                            break;
                        end
                    end
                end
            end
            default: ;  // unused mode answers ok with no change
        endcase
        return w;
    endfunction

    function automatic void log_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_MAX) $display("[%0t] checker: %s", $realtime, what);
    endfunction

    // predict on request accept, compare on response accept
    always @(posedge i_clk) begin
        t_rsp_word want;
        if (!i_rst_n) begin
            used_mark = '{default: 1'b0};
            expected_words.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                expected_words.push_back(alloc_outcome(i_req.mode, i_req.page_number,
                                                       i_req.block_order));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_words.size() == 0) begin
                    log_fault($sformatf("unexpected word: status %0d block_page %0h",
                                        i_rsp.status, i_rsp.block_page));
                end else begin
                    want = expected_words.pop_front();
                    if (i_rsp.status !== want.status || i_rsp.block_page !== want.block_page)
                        log_fault($sformatf({"mismatch: status exp %0d got %0d, ",
                                             "block_page exp %0h got %0h"},
                                            want.status, i_rsp.status,
                                            want.block_page, i_rsp.block_page));
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

@@ tb/tb_buddy_tree_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Buddy tree page allocator: testbench top
// Drives a directed run over the corner cases, then random page claims,
// frees, block claims and unused-mode words with idle bursts on both channels.
// The checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_buddy_tree_page_allocator_unit;
    import bta_pkg::*;

    localparam int               PAGE_INDEX_BITS = 16;
    localparam int               RANDOM_WORDS    = 1800;
    localparam int               QUIET_FROM      = 1600;
    localparam int               STALL_LIMIT     = 200000;
    localparam int               DRAIN_CYCLES    = 64;
    localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   error_count;
    int   pending_words;
    int   idle_cycles = 0;

    logic [PAGE_W-1:0] claimed_pages [$];

    bta_req_if req_ch ();
    bta_rsp_if rsp_ch ();

    buddy_tree_page_allocator_unit #(
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bta_alloc_checker #(
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
    ) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (error_count),
        .o_pending (pending_words)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // send one request word, called at a falling edge, returns at a falling edge
    task automatic send_word(
        input logic [MODE_W-1:0]  mode,
        input logic [PAGE_W-1:0]  page,
        input logic [ORDER_W-1:0] order
    );
        int gap;
        // occasional idle burst before the word
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.page_number <= page;
        req_ch.block_order <= order;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (mode == MODE_CLAIM_PAGE) claimed_pages.push_back(page);
    endtask

    // response back-pressure: ready spans mixed with stall bursts
    initial begin : rsp_ready_drive
        int span;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet || $urandom_range(0, 3) != 0) begin
                rsp_ch.ready <= 1'b1;
                span = $urandom_range(1, 48);
            end else begin
                rsp_ch.ready <= 1'b0;
                span = $urandom_range(1, 16);
            end
            repeat (span - 1) @(negedge i_clk);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin
        int                 sel;
        int                 pick;
        logic [MODE_W-1:0]  mode;
        logic [PAGE_W-1:0]  page;
        logic [ORDER_W-1:0] order;

        quiet              = 1'b0;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_CLAIM_PAGE;
        req_ch.page_number = '0;
        req_ch.block_order = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: page extremes, buddy stop on free, full-tree free back to root
        send_word(MODE_CLAIM_PAGE, 16'h0000, 5'd0);
        send_word(MODE_CLAIM_PAGE, 16'h0000, 5'd0);    // already claimed
        send_word(MODE_CLAIM_PAGE, 16'hFFFF, 5'd0);
        send_word(MODE_CLAIM_PAGE, 16'h0001, 5'd0);
        send_word(MODE_FREE_PAGE,  16'h0000, 5'd0);    // buddy still held
        send_word(MODE_FREE_PAGE,  16'h0001, 5'd0);
        send_word(MODE_FREE_PAGE,  16'h0001, 5'd0);    // already free
        send_word(MODE_FREE_PAGE,  16'hFFFF, 5'd0);    // clears up to the root
        // block claims: whole tree, exhausted rows, order too large, overlap
        send_word(MODE_CLAIM_BLOCK, 16'h0000, 5'd16);
        send_word(MODE_CLAIM_BLOCK, 16'h0000, 5'd16);  // row full
        send_word(MODE_CLAIM_BLOCK, 16'hFFFF, 5'd17);
        send_word(MODE_CLAIM_BLOCK, 16'h0000, 5'd31);
        send_word(MODE_CLAIM_BLOCK, 16'h0000, 5'd0);   // overlaps the whole-tree block
        send_word(MODE_CLAIM_BLOCK, 16'h0000, 5'd15);
        send_word(MODE_CLAIM_BLOCK, 16'h0000, 5'd15);  // row full
        send_word(MODE_CLAIM_PAGE,  16'h0000, 5'd0);
        send_word(MODE_UNUSED,      16'hFFFF, 5'd31);
        send_word(MODE_UNUSED,      16'h0000, 5'd0);
        send_word(MODE_CLAIM_BLOCK, 16'h0000, 5'd1);
        send_word(MODE_FREE_PAGE,   16'h0000, 5'd0);
        send_word(MODE_CLAIM_BLOCK, 16'h0000, 5'd14);
        send_word(MODE_FREE_PAGE,   16'h8000, 5'd0);   // block leaf never marked
        send_word(MODE_CLAIM_PAGE,  16'h8000, 5'd0);
        send_word(MODE_CLAIM_BLOCK, 16'h0000, 5'd8);
        send_word(MODE_FREE_PAGE,   16'hFFFF, 5'd0);

        // random: claims clustered low so that buddies meet, frees mostly of held pages
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == QUIET_FROM) quiet = 1'b1;
            sel   = $urandom_range(0, 99);
            page  = PAGE_W'($urandom);
            order = ORDER_W'($urandom);
            if (sel < 35) begin
                mode = MODE_CLAIM_PAGE;
                if ($urandom_range(0, 9) < 7) page = PAGE_W'($urandom_range(0, 255));
            end else if (sel < 60) begin
                mode = MODE_FREE_PAGE;
                if (claimed_pages.size() != 0 && $urandom_range(0, 9) < 8) begin
                    pick = $urandom_range(0, claimed_pages.size() - 1);
                    page = claimed_pages[pick];
                    claimed_pages.delete(pick);
                end else begin
                    page = PAGE_W'($urandom_range(0, 255));
                end
            end else if (sel < 90) begin
                mode = MODE_CLAIM_BLOCK;
                pick = $urandom_range(0, 19);
                if (pick < 15)      order = ORDER_W'($urandom_range(8, 16));
                else if (pick < 18) order = ORDER_W'($urandom_range(0, 7));
                else                order = ORDER_W'($urandom_range(17, 31));
            end else if (sel < 95) begin
                mode = MODE_UNUSED;
            end else begin
                mode = MODE_CLAIM_PAGE;
            end
            send_word(mode, page, order);
        end
        req_ch.valid <= 1'b0;

        // drain, then a margin for stray words
        while (pending_words != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
